// ----- rtl/eda_pkg.sv -----
// ----------------------------------------------------------------------------
// eda_pkg
// shared types and constants of the edit distance alignment block
// ----------------------------------------------------------------------------
package eda_pkg;

  localparam int unsigned CW = 8;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] COST_MATCH    = 2'd0;
  localparam logic [1:0] COST_MISMATCH = 2'd1;
  localparam logic [1:0] COST_GAP      = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } req_t;

  typedef struct packed {
    logic       column_valid;
    logic [7:0] a_symbol;
    logic       a_is_gap;
    logic [7:0] b_symbol;
    logic       b_is_gap;
    logic [1:0] column_cost;
    logic [7:0] distance;
    logic       last;
    logic       overflow;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BCOL,
    ST_BROW,
    ST_FRD,
    ST_FCALC,
    ST_DRD,
    ST_DCAP,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_TAIL_RD,
    ST_TAIL_EM,
    ST_EMPTY
  } state_e;

endpackage

// ----- rtl/eda_sym_mem.sv -----
// ----------------------------------------------------------------------------
// eda_sym_mem
// symbol store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module eda_sym_mem #(
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/eda_cost_mem.sv -----
// ----------------------------------------------------------------------------
// eda_cost_mem
// suffix cost table, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module eda_cost_mem import eda_pkg::*; #(
  parameter int unsigned DEPTH = 1089,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [CW-1:0] rdata_o
);

  logic [CW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/edit_distance_alignment.sv -----
// ----------------------------------------------------------------------------
// edit_distance_alignment
// global alignment of two byte strings with suffix cost table and traceback
// ----------------------------------------------------------------------------
// channel   dir  ports               handshake
// request   in   start, req_i        taken when start high and busy low
// result    out  valid_o, res_o      one cycle per result, no back pressure
//
// loads are taken while idle and leave busy low. a compute writes the border
// column and row, fills each cell with a read state and a write state, reads
// the distance, then steps through T0 to T3 per diagonal or gap step and through a read and an emit state per end gap.
// reset clears lengths, flag and control; memories need no clearing.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module edit_distance_alignment import eda_pkg::*; #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned ROW = MAX_LEN + 1;
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned TD  = ROW * ROW;
  localparam int unsigned TAW = $clog2(TD);

  state_e state_q, state_d;
  logic [LW-1:0] la_q, la_d, lb_q, lb_d, i_q, i_d, j_q, j_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] right_q, right_d, diag_q, diag_d, here_q, here_d, dist_q, dist_d;
  logic          valid_q, valid_d;
  res_t          res_q, res_d;

  logic          accept;
  logic          a_we, b_we, t_we, t_re;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [CW-1:0] t_wdata, t_rdata;
  logic [7:0]    a_rd, b_rd;

  logic [CW:0]   sum_v, sum_h, sum_d;
  logic [CW-1:0] best;
  logic          sub;
  logic [LW-1:0] ni, nj;

  function automatic logic [TAW-1:0] taddr(input logic [LW-1:0] r, input logic [LW-1:0] c);
    taddr = TAW'(r) * TAW'(ROW) + TAW'(c);
  endfunction

  function automatic logic [CW-1:0] gap2(input logic [LW-1:0] v);
    gap2 = CW'({v, 1'b0});
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign a_we   = accept && (req_i.kind == KIND_LOAD_A) && (la_q < LW'(MAX_LEN));
  assign b_we   = accept && (req_i.kind == KIND_LOAD_B) && (lb_q < LW'(MAX_LEN));

  eda_sym_mem #(.AW(SAW)) u_mem_a (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(la_q[SAW-1:0]),
    .wdata_i(req_i.symbol),
    .raddr_i(i_q[SAW-1:0]),
    .rdata_o(a_rd)
  );

  eda_sym_mem #(.AW(SAW)) u_mem_b (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(lb_q[SAW-1:0]),
    .wdata_i(req_i.symbol),
    .raddr_i(j_q[SAW-1:0]),
    .rdata_o(b_rd)
  );

  eda_cost_mem #(.DEPTH(TD), .AW(TAW)) u_cost (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .re_i   (t_re),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  assign sub   = (a_rd != b_rd);
  assign sum_v = {1'b0, right_q} + (CW+1)'(COST_GAP);
  assign sum_h = {1'b0, t_rdata} + (CW+1)'(COST_GAP);
  assign sum_d = {1'b0, diag_q} + (CW+1)'(sub);

  always_comb begin
    logic [CW:0] m;
    m = sum_v;
    if (sum_h < m) m = sum_h;
    if (sum_d < m) m = sum_d;
    best = m[CW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    ni = i_q;
    nj = j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.kind == KIND_COMPUTE) state_d = ST_BCOL;
      end
      ST_BCOL: begin
        if (i_q == la_q) state_d = ST_BROW;
      end
      ST_BROW: begin
        if (j_q == lb_q) begin
          state_d = (la_q == '0 || lb_q == '0) ? ST_DRD : ST_FRD;
        end
      end
      ST_FRD:   state_d = ST_FCALC;
      ST_FCALC: state_d = (i_q == '0 && j_q == '0) ? ST_DRD : ST_FRD;
      ST_DRD:   state_d = ST_DCAP;
      ST_DCAP: begin
        if (la_q == '0 && lb_q == '0)      state_d = ST_EMPTY;
        else if (la_q != '0 && lb_q != '0) state_d = ST_T0;
        else                               state_d = ST_TAIL_RD;
      end
      ST_T0: state_d = ST_T1;
      ST_T1: state_d = ST_T2;
      ST_T2: state_d = ST_T3;
      ST_T3: begin
        if (here_q == CW'(sum_d)) begin
          ni = i_q + 1'b1;
          nj = j_q + 1'b1;
        end else if ({1'b0, here_q} == sum_h) begin
          ni = i_q + 1'b1;
        end else begin
          nj = j_q + 1'b1;
        end
        if (ni == la_q && nj == lb_q)     state_d = ST_IDLE;
        else if (ni != la_q && nj != lb_q) state_d = ST_T0;
        else                               state_d = ST_TAIL_RD;
      end
      ST_TAIL_RD: state_d = ST_TAIL_EM;
      ST_TAIL_EM: begin
        if (i_q != la_q) ni = i_q + 1'b1;
        else             nj = j_q + 1'b1;
        state_d = (ni == la_q && nj == lb_q) ? ST_IDLE : ST_TAIL_RD;
      end
      ST_EMPTY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    la_d    = la_q;
    lb_d    = lb_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    right_d = right_q;
    diag_d  = diag_q;
    here_d  = here_q;
    dist_d  = dist_q;
    valid_d = 1'b0;
    res_d   = res_q;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_re    = 1'b0;
    t_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.kind)
            KIND_LOAD_A: begin
              if (a_we) la_d = la_q + 1'b1;
              else      ovf_d = 1'b1;
            end
            KIND_LOAD_B: begin
              if (b_we) lb_d = lb_q + 1'b1;
              else      ovf_d = 1'b1;
            end
            KIND_COMPUTE: i_d = '0;
            default: ;
          endcase
        end
      end
      ST_BCOL: begin
        t_we    = 1'b1;
        t_waddr = taddr(i_q, lb_q);
        t_wdata = gap2(la_q - i_q);
        if (i_q == la_q) j_d = '0;
        else             i_d = i_q + 1'b1;
      end
      ST_BROW: begin
        t_we    = 1'b1;
        t_waddr = taddr(la_q, j_q);
        t_wdata = gap2(lb_q - j_q);
        if (j_q == lb_q) begin
          i_d     = la_q - 1'b1;
          j_d     = lb_q - 1'b1;
          right_d = gap2(LW'(1));
          diag_d  = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_FRD: begin
        t_re    = 1'b1;
        t_raddr = taddr(i_q + 1'b1, j_q);
      end
      ST_FCALC: begin
        t_we    = 1'b1;
        t_waddr = taddr(i_q, j_q);
        t_wdata = best;
        right_d = best;
        diag_d  = t_rdata;
        if (j_q == '0) begin
          if (i_q != '0) begin
            i_d     = i_q - 1'b1;
            j_d     = lb_q - 1'b1;
            right_d = gap2(la_q - i_q + 1'b1);
            diag_d  = gap2(la_q - i_q);
          end
        end else begin
          j_d = j_q - 1'b1;
        end
      end
      ST_DRD: begin
        t_re    = 1'b1;
        t_raddr = '0;
      end
      ST_DCAP: begin
        dist_d = t_rdata;
        i_d    = '0;
        j_d    = '0;
      end
      ST_T0: begin
        t_re    = 1'b1;
        t_raddr = taddr(i_q, j_q);
      end
      ST_T1: begin
        here_d  = t_rdata;
        t_re    = 1'b1;
        t_raddr = taddr(i_q + 1'b1, j_q + 1'b1);
      end
      ST_T2: begin
        diag_d  = t_rdata;
        t_re    = 1'b1;
        t_raddr = taddr(i_q + 1'b1, j_q);
      end
      ST_T3: begin
        valid_d            = 1'b1;
        res_d.column_valid = 1'b1;
        res_d.distance     = dist_q;
        res_d.overflow     = ovf_q;
        res_d.last         = (ni == la_q && nj == lb_q);
        if (here_q == CW'(sum_d)) begin
          res_d.a_symbol    = a_rd;
          res_d.a_is_gap    = 1'b0;
          res_d.b_symbol    = b_rd;
          res_d.b_is_gap    = 1'b0;
          res_d.column_cost = sub ? COST_MISMATCH : COST_MATCH;
        end else if ({1'b0, here_q} == sum_h) begin
          res_d.a_symbol    = a_rd;
          res_d.a_is_gap    = 1'b0;
          res_d.b_symbol    = '0;
          res_d.b_is_gap    = 1'b1;
          res_d.column_cost = COST_GAP;
        end else begin
          res_d.a_symbol    = '0;
          res_d.a_is_gap    = 1'b1;
          res_d.b_symbol    = b_rd;
          res_d.b_is_gap    = 1'b0;
          res_d.column_cost = COST_GAP;
        end
        i_d = ni;
        j_d = nj;
      end
      ST_TAIL_RD: ;
      ST_TAIL_EM: begin
        valid_d            = 1'b1;
        res_d.column_valid = 1'b1;
        res_d.distance     = dist_q;
        res_d.overflow     = ovf_q;
        res_d.last         = (ni == la_q && nj == lb_q);
        res_d.column_cost  = COST_GAP;
        if (i_q != la_q) begin
          res_d.a_symbol = a_rd;
          res_d.a_is_gap = 1'b0;
          res_d.b_symbol = '0;
          res_d.b_is_gap = 1'b1;
        end else begin
          res_d.a_symbol = '0;
          res_d.a_is_gap = 1'b1;
          res_d.b_symbol = b_rd;
          res_d.b_is_gap = 1'b0;
        end
        i_d = ni;
        j_d = nj;
      end
      ST_EMPTY: begin
        valid_d      = 1'b1;
        res_d        = '0;
        res_d.last   = 1'b1;
        res_d.overflow = ovf_q;
      end
      default: ;
    endcase
    if (valid_d && res_d.last) begin
      la_d  = '0;
      lb_d  = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      la_q    <= '0;
      lb_q    <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      la_q    <= la_d;
      lb_q    <= lb_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    right_q <= right_d;
    diag_q  <= diag_d;
    here_q  <= here_d;
    dist_q  <= dist_d;
    res_q   <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTH
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.last |-> !busy) else $error("last result while busy");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.column_valid |-> res_o.last) else $error("empty result not last");
  a_one_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(res_o.a_is_gap && res_o.b_is_gap)) else $error("double gap column");
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (la_q <= LW'(MAX_LEN)) && (lb_q <= LW'(MAX_LEN))) else $error("length overrun");
`endif

endmodule

// ----- test/tb_edit_distance_alignment.sv -----
// ----------------------------------------------------------------------------
// tb_edit_distance_alignment
// self-checking bench for the edit distance alignment block: requests load
// two strings and compute, a scoreboard predicts every alignment column and
// compares each result field by field
// ----------------------------------------------------------------------------
module tb_edit_distance_alignment;
  import eda_pkg::*;

  localparam int unsigned MAXL = 32;

  class align_scoreboard;
    logic [7:0] str_a[MAXL];
    logic [7:0] str_b[MAXL];
    int unsigned len_a;
    int unsigned len_b;
    bit dropped;
    res_t pending[$];
    int unsigned errors;

    function new();
      len_a = 0;
      len_b = 0;
      dropped = 0;
      errors = 0;
    endfunction

    function void add_column(logic cv, logic [7:0] as, logic ag, logic [7:0] bs,
                             logic bg, logic [1:0] cc, logic [7:0] total);
      res_t r;
      r.column_valid = cv;
      r.a_symbol = as;
      r.a_is_gap = ag;
      r.b_symbol = bs;
      r.b_is_gap = bg;
      r.column_cost = cc;
      r.distance = total;
      r.last = 1'b0;
      r.overflow = dropped;
      pending.push_back(r);
    endfunction

    function void note_request(req_t q);
      int unsigned tbl[MAXL+1][MAXL+1];
      int unsigned i;
      int unsigned j;
      int unsigned v;
      int unsigned p;
      int unsigned total;
      int unsigned before_cnt;
      res_t r;
      if (q.kind == KIND_LOAD_A) begin
        if (len_a < MAXL) begin
          str_a[len_a] = q.symbol;
          len_a++;
        end else begin
          dropped = 1;
        end
      end else if (q.kind == KIND_LOAD_B) begin
        if (len_b < MAXL) begin
          str_b[len_b] = q.symbol;
          len_b++;
        end else begin
          dropped = 1;
        end
      end else if (q.kind == KIND_COMPUTE) begin
        before_cnt = pending.size();
        for (i = 0; i <= len_a; i++) tbl[i][len_b] = 2 * (len_a - i);
        for (j = 0; j <= len_b; j++) tbl[len_a][j] = 2 * (len_b - j);
        for (int ii = int'(len_a) - 1; ii >= 0; ii--) begin
          for (int jj = int'(len_b) - 1; jj >= 0; jj--) begin
            v = tbl[ii][jj+1] + 2;
            if (tbl[ii+1][jj] + 2 < v) v = tbl[ii+1][jj] + 2;
            p = (str_a[ii] == str_b[jj]) ? 0 : 1;
            if (tbl[ii+1][jj+1] + p < v) v = tbl[ii+1][jj+1] + p;
            tbl[ii][jj] = v;
          end
        end
        total = tbl[0][0];
        i = 0;
        j = 0;
        while (i < len_a && j < len_b) begin
          p = (str_a[i] == str_b[j]) ? 0 : 1;
          if (tbl[i][j] == tbl[i+1][j+1] + p) begin
            add_column(1, str_a[i], 0, str_b[j], 0,
                       p ? COST_MISMATCH : COST_MATCH, total);
            i++;
            j++;
          end else if (tbl[i][j] == tbl[i+1][j] + 2) begin
            add_column(1, str_a[i], 0, 8'd0, 1, COST_GAP, total);
            i++;
          end else begin
            add_column(1, 8'd0, 1, str_b[j], 0, COST_GAP, total);
            j++;
          end
        end
        for (; i < len_a; i++) add_column(1, str_a[i], 0, 8'd0, 1, COST_GAP, total);
        for (; j < len_b; j++) add_column(1, 8'd0, 1, str_b[j], 0, COST_GAP, total);
        if (pending.size() == before_cnt) add_column(0, 8'd0, 0, 8'd0, 0, COST_MATCH, 8'd0);
        r = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
        len_a = 0;
        len_b = 0;
        dropped = 0;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.column_valid !== e.column_valid) begin
        $error("column_valid exp %0d got %0d", e.column_valid, got.column_valid);
        errors++;
      end
      if (got.a_symbol !== e.a_symbol) begin
        $error("a_symbol exp %0h got %0h", e.a_symbol, got.a_symbol);
        errors++;
      end
      if (got.a_is_gap !== e.a_is_gap) begin
        $error("a_is_gap exp %0d got %0d", e.a_is_gap, got.a_is_gap);
        errors++;
      end
      if (got.b_symbol !== e.b_symbol) begin
        $error("b_symbol exp %0h got %0h", e.b_symbol, got.b_symbol);
        errors++;
      end
      if (got.b_is_gap !== e.b_is_gap) begin
        $error("b_is_gap exp %0d got %0d", e.b_is_gap, got.b_is_gap);
        errors++;
      end
      if (got.column_cost !== e.column_cost) begin
        $error("column_cost exp %0d got %0d", e.column_cost, got.column_cost);
        errors++;
      end
      if (got.distance !== e.distance) begin
        $error("distance exp %0d got %0d", e.distance, got.distance);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last);
        errors++;
      end
      if (got.overflow !== e.overflow) begin
        $error("overflow exp %0d got %0d", e.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic valid_o;
  res_t res_o;
  int unsigned idle_pct = 0;
  align_scoreboard align_sb;

  edit_distance_alignment dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .req_i(req_i),
    .busy(busy),
    .valid_o(valid_o),
    .res_o(res_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) align_sb.note_request(req_i);
    if (rst_ni && valid_o) align_sb.check_result(res_o);
  end

  // request held until taken, random gaps before it
  task automatic send_request(logic [1:0] kind, logic [7:0] sym);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{kind: kind, symbol: sym};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (align_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // random pair of the given lengths, with a small alphabet when alpha is nonzero so matches occur
  task automatic send_pair(int unsigned la, int unsigned lb, int unsigned alpha);
    for (int unsigned k = 0; k < la; k++)
      send_request(KIND_LOAD_A, alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha)));
    for (int unsigned k = 0; k < lb; k++)
      send_request(KIND_LOAD_B, alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha)));
    send_request(KIND_COMPUTE, 8'($urandom));
  endtask

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned la;
    int unsigned lb;
    align_sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pair
    send_request(KIND_COMPUTE, 8'hff);
    // extremes, match, mismatch
    send_request(KIND_LOAD_A, 8'h00);
    send_request(KIND_LOAD_A, 8'hff);
    send_request(KIND_LOAD_B, 8'h00);
    send_request(KIND_LOAD_B, 8'h55);
    send_request(KIND_COMPUTE, 8'h00);
    // only A, then only B, end gaps
    send_request(KIND_LOAD_A, 8'haa);
    send_request(KIND_LOAD_A, 8'h55);
    send_request(KIND_COMPUTE, 8'h00);
    send_request(KIND_LOAD_B, 8'h0f);
    send_request(KIND_COMPUTE, 8'h00);
    // ignored kind
    send_request(2'd3, 8'hf0);
    // gap in middle with ties
    send_request(KIND_LOAD_A, 8'h01);
    send_request(KIND_LOAD_A, 8'h02);
    send_request(KIND_LOAD_A, 8'h03);
    send_request(KIND_LOAD_B, 8'h01);
    send_request(KIND_LOAD_B, 8'h03);
    send_request(KIND_COMPUTE, 8'h00);
    // overflow on full strings: fill A and B beyond full, then compute
    for (int k = 0; k < 33; k++) send_request(KIND_LOAD_A, 8'($urandom));
    for (int k = 0; k < 33; k++) send_request(KIND_LOAD_B, 8'($urandom_range(3)));
    send_request(KIND_COMPUTE, 8'h00);
    drain();

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 53 : (ph == 2) ? 0 : 38;
      while (n < 50 * (ph + 1)) begin
        if ($urandom_range(9) == 0) begin
          send_request(2'($urandom_range(3)), 8'($urandom));
          n++;
        end else begin
          la = $urandom_range(6);
          lb = $urandom_range(6);
          if ($urandom_range(19) == 0) la = $urandom_range(28, 33);
          send_pair(la, lb, $urandom_range(1) ? 3 : 0);
          n += la + lb + 1;
        end
      end
      drain();
    end

    send_request(KIND_COMPUTE, 8'h00);
    drain();
    repeat (50) @(posedge clk_i);
    if (align_sb.errors == 0 && align_sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/eda_pkg.sv
rtl/eda_sym_mem.sv
rtl/eda_cost_mem.sv
rtl/edit_distance_alignment.sv
test/tb_edit_distance_alignment.sv
